[hdl/cbm_pkg.sv]
// Shared types and constants of the cartridge bank mapper.
package cbm_pkg;

    // Item kinds on the input side
    localparam logic [2:0] MODE_CPU_RD = 3'd0;
    localparam logic [2:0] MODE_CPU_WR = 3'd1;
    localparam logic [2:0] MODE_PPU_RD = 3'd2;
    localparam logic [2:0] MODE_PPU_WR = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;

    // Target memory codes on the output side
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR     = 3'd3;
    localparam logic [2:0] TGT_VRAM    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT   = 2'd1;
    localparam logic [1:0] CFG_CHR_IS_RAM  = 2'd2;
    localparam logic [1:0] CFG_MIRROR_INIT = 2'd3;

    // Mapper register groups, selected by address bits 14:13
    localparam logic [1:0] GRP_BANK   = 2'd0;
    localparam logic [1:0] GRP_MIRROR = 2'd1;
    localparam logic [1:0] GRP_IRQ    = 2'd2;
    localparam logic [1:0] GRP_IRQ_EN = 2'd3;

    localparam int PRG_CNT_W     = 7;
    localparam int CHR_CNT_W     = 9;
    localparam int MAX_PRG_BANKS = 64;
    localparam int MAX_CHR_BANKS = 256;
    localparam int BANK_W        = 8;
    localparam int DIV_W         = 2 * BANK_W;
    localparam int STEP_W        = 3;
    localparam int IRQ_IDLE_FIRST = 240;
    localparam int IRQ_IDLE_LAST  = 260;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } status_t;

endpackage

[hdl/cartridge_bank_mapper_irq_unit.sv]
// Top level of the cartridge bank mapper with scanline interrupt counter.
//
// Input channel (s_*): one transfer per bus access or scanline tick. s_tuser
// carries the item kind, s_tdata the address, write byte, scanline and the
// rendering flag. Output channel (m_*): one transfer per accepted item with
// the target memory in m_tuser and offset, write strobe, write byte,
// read-zero flag and interrupt level in m_tdata.
// Configuration: cfg_wr_en writes register cfg_index (0 program bank count,
// 1 pattern bank count, 2 pattern memory is RAM, 3 reset mirroring) with
// cfg_wdata; write only while the block is idle.
// Items that hit a banked window (program ROM, pattern memory) pass through
// the divide state, since the bank number is reduced modulo the bank count by
// an 8-step restoring remainder unit, one bit per cycle; all other items go
// straight to the load state. One item is in work at a time, so a new item is
// taken only after the last one has been loaded into the output register.
// Register writes and ticks take effect at the input transfer; the irq bit
// reports the line after the item.
// Reset clears all mapper registers and loads the default configuration.
// A stalled receiver holds the result in the output register; a new item may
// be taken meanwhile and waits in the load stage until the register frees.
module cartridge_bank_mapper_irq_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[15:0], data[23:16], scanline[32:24], rendering[33]
    input  logic [2:0]  s_tuser,   // mode[2:0]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // mem_address[18:0], write_enable[19], write_data[27:20],
                                   // read_zero[28], irq[29]
    output logic [2:0]  m_tuser    // target[2:0]
);

    cbm_pkg::cmd_t    cmd;
    cbm_pkg::status_t status;

    // Sequencer: accept, iterate the remainder, load the output register
    cbm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Mapper registers, address translation and result register
    cbm_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    // An accepted item occupies the block: no second transfer on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    // A result with no target never carries a write strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == cbm_pkg::TGT_NONE) |-> !m_tdata[19])
        else $error("write strobe without target");

    // Read-zero only on a result with no target
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[28]) |-> (m_tuser == cbm_pkg::TGT_NONE))
        else $error("read-zero with a target");
`endif

endmodule

[hdl/cbm_ctrl.sv]
// Controller state machine of the cartridge bank mapper.
module cbm_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  cbm_pkg::status_t status,
    output cbm_pkg::cmd_t    cmd
);

    cbm_pkg::state_t state_reg;
    cbm_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.need_div ? cbm_pkg::ST_DIVIDE : cbm_pkg::ST_LOAD;
                end
            end
            cbm_pkg::ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = cbm_pkg::ST_LOAD;
                end
            end
            cbm_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = cbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            cbm_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            cbm_pkg::ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            cbm_pkg::ST_LOAD:
            begin
                cmd.load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold the result until taken; a new load may replace one being taken
    assign out_valid_next = cmd.load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign m_tvalid       = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/cbm_datapath.sv]
// Datapath of the cartridge bank mapper: registers, decode, bank modulo and result.
module cbm_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  cbm_pkg::cmd_t    cmd,
    output cbm_pkg::status_t status,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [8:0]       cfg_wdata,
    input  logic [39:0]      s_tdata,
    input  logic [2:0]       s_tuser,
    output logic [31:0]      m_tdata,
    output logic [2:0]       m_tuser
);

    // Configuration
    logic [cbm_pkg::PRG_CNT_W-1:0] prg_count_reg;
    logic [cbm_pkg::CHR_CNT_W-1:0] chr_count_reg;
    logic                          chr_is_ram_reg;

    // Mapper state
    logic [7:0] bank_select_reg;
    logic [7:0] bank_regs_reg [8];
    logic       mirror_h_reg;
    logic       ram_enable_reg;
    logic       ram_writable_reg;
    logic [7:0] irq_counter_reg;
    logic [7:0] irq_reload_reg;
    logic       irq_enable_reg;
    logic       irq_line_reg;

    // Item under work
    logic [2:0]                       tgt_reg;
    logic [12:0]                      low_reg;
    logic                             we_reg;
    logic [7:0]                       wd_reg;
    logic                             rz_reg;
    logic [cbm_pkg::BANK_W-1:0]       rem_reg;
    logic [cbm_pkg::DIV_W-1:0]        div_reg;
    logic [cbm_pkg::STEP_W-1:0]       cnt_reg;

    // Result
    logic [2:0]  out_tgt_reg;
    logic [18:0] out_addr_reg;
    logic        out_we_reg;
    logic [7:0]  out_wd_reg;
    logic        out_rz_reg;
    logic        out_irq_reg;

    // Input fields
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        rendering;

    assign mode      = s_tuser;
    assign address   = s_tdata[15:0];
    assign data      = s_tdata[23:16];
    assign scanline  = s_tdata[32:24];
    assign rendering = s_tdata[33];

    // Clamped bank counts
    logic [cbm_pkg::PRG_CNT_W-1:0] prg_n;
    logic [cbm_pkg::CHR_CNT_W-1:0] chr_n;
    logic [cbm_pkg::PRG_CNT_W-1:0] prg_last;
    logic [cbm_pkg::PRG_CNT_W-1:0] prg_second;

    always_comb
    begin
        if (prg_count_reg == '0)
            prg_n = cbm_pkg::PRG_CNT_W'(1);
        else if (prg_count_reg > cbm_pkg::PRG_CNT_W'(cbm_pkg::MAX_PRG_BANKS))
            prg_n = cbm_pkg::PRG_CNT_W'(cbm_pkg::MAX_PRG_BANKS);
        else
            prg_n = prg_count_reg;
        if (chr_count_reg == '0)
            chr_n = cbm_pkg::CHR_CNT_W'(1);
        else if (chr_count_reg > cbm_pkg::CHR_CNT_W'(cbm_pkg::MAX_CHR_BANKS))
            chr_n = cbm_pkg::CHR_CNT_W'(cbm_pkg::MAX_CHR_BANKS);
        else
            chr_n = chr_count_reg;
        prg_last   = prg_n - cbm_pkg::PRG_CNT_W'(1);
        prg_second = (prg_last != '0) ? prg_last - cbm_pkg::PRG_CNT_W'(1) : prg_last;
    end

    // Window bank choice
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;
    logic [2:0] chr_win;
    logic [7:0] chr_pair;

    always_comb
    begin
        case (address[14:13])
            2'd0:    prg_bank = bank_select_reg[6] ? 8'(prg_second) : bank_regs_reg[6];
            2'd1:    prg_bank = bank_regs_reg[7];
            2'd2:    prg_bank = bank_select_reg[6] ? bank_regs_reg[6] : 8'(prg_second);
            default: prg_bank = 8'(prg_last);
        endcase
        chr_win  = address[12:10] ^ {bank_select_reg[7], 2'b00};
        chr_pair = bank_regs_reg[{2'b00, chr_win[1]}];
        if (!chr_win[2])
            chr_bank = chr_win[0] ? (chr_pair | 8'h01) : (chr_pair & 8'hFE);
        else
            chr_bank = bank_regs_reg[3'(chr_win[1:0]) + 3'd2];
    end

    // Decode of the offered item
    logic [2:0]               tgt_acc;
    logic [12:0]              low_acc;
    logic                     we_acc;
    logic [7:0]               wd_acc;
    logic                     rz_acc;
    logic [7:0]               bank_acc;
    logic [cbm_pkg::DIV_W-1:0] div_acc;
    logic [10:0]              nt_off;

    assign nt_off = mirror_h_reg ? {address[11], address[9:0]} : address[10:0];

    always_comb
    begin
        tgt_acc  = cbm_pkg::TGT_NONE;
        low_acc  = '0;
        we_acc   = 1'b0;
        wd_acc   = '0;
        rz_acc   = 1'b0;
        bank_acc = '0;
        div_acc  = '0;
        unique case (mode)
            cbm_pkg::MODE_CPU_RD:
            begin
                if (!address[15])
                begin
                    if (ram_enable_reg)
                    begin
                        tgt_acc = cbm_pkg::TGT_PRG_RAM;
                        low_acc = address[12:0];
                    end
                    else
                    begin
                        rz_acc = 1'b1;
                    end
                end
                else
                begin
                    tgt_acc  = cbm_pkg::TGT_PRG_ROM;
                    low_acc  = address[12:0];
                    bank_acc = prg_bank;
                    div_acc  = {2'b00, prg_n, 7'b0};
                end
            end
            cbm_pkg::MODE_CPU_WR:
            begin
                wd_acc = data;
                if (!address[15] && address[14:13] == 2'b11 && ram_writable_reg)
                begin
                    tgt_acc = cbm_pkg::TGT_PRG_RAM;
                    low_acc = address[12:0];
                    we_acc  = 1'b1;
                end
            end
            cbm_pkg::MODE_PPU_RD,
            cbm_pkg::MODE_PPU_WR:
            begin
                if (mode == cbm_pkg::MODE_PPU_WR)
                    wd_acc = data;
                if (address[13])
                begin
                    tgt_acc = cbm_pkg::TGT_VRAM;
                    low_acc = {2'b00, nt_off};
                    we_acc  = (mode == cbm_pkg::MODE_PPU_WR);
                end
                else
                begin
                    tgt_acc  = cbm_pkg::TGT_CHR;
                    low_acc  = {3'b000, address[9:0]};
                    bank_acc = chr_bank;
                    div_acc  = {chr_n, 7'b0};
                    we_acc   = (mode == cbm_pkg::MODE_PPU_WR) && chr_is_ram_reg;
                end
            end
            default:
            begin
                tgt_acc = cbm_pkg::TGT_NONE;
            end
        endcase
    end

    assign status.need_div = (tgt_acc == cbm_pkg::TGT_PRG_ROM) || (tgt_acc == cbm_pkg::TGT_CHR);
    assign status.div_last = (cnt_reg == '0);

    // Register write and tick decode
    logic       reg_wr;
    logic       tick_run;
    logic [2:0] sel_r;
    logic [7:0] bank_wval;

    assign reg_wr   = cmd.accept && (mode == cbm_pkg::MODE_CPU_WR) && address[15];
    assign tick_run = cmd.accept && (mode == cbm_pkg::MODE_TICK) && rendering
                      && !(scanline >= 9'(cbm_pkg::IRQ_IDLE_FIRST)
                           && scanline <= 9'(cbm_pkg::IRQ_IDLE_LAST));
    assign sel_r    = bank_select_reg[2:0];

    always_comb
    begin
        if (sel_r < 3'd2)
            bank_wval = data & 8'hFE;
        else if (sel_r >= 3'd6)
            bank_wval = data & 8'h3F;
        else
            bank_wval = data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg    <= cbm_pkg::PRG_CNT_W'(2);
            chr_count_reg    <= cbm_pkg::CHR_CNT_W'(8);
            chr_is_ram_reg   <= 1'b0;
            bank_select_reg  <= '0;
            for (int i = 0; i < 8; i++)
                bank_regs_reg[i] <= '0;
            mirror_h_reg     <= 1'b0;
            ram_enable_reg   <= 1'b0;
            ram_writable_reg <= 1'b0;
            irq_counter_reg  <= '0;
            irq_reload_reg   <= '0;
            irq_enable_reg   <= 1'b0;
            irq_line_reg     <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    cbm_pkg::CFG_PRG_COUNT:   prg_count_reg  <= cfg_wdata[6:0];
                    cbm_pkg::CFG_CHR_COUNT:   chr_count_reg  <= cfg_wdata;
                    cbm_pkg::CFG_CHR_IS_RAM:  chr_is_ram_reg <= cfg_wdata[0];
                    cbm_pkg::CFG_MIRROR_INIT: mirror_h_reg   <= cfg_wdata[0];
                    default:                  chr_is_ram_reg <= chr_is_ram_reg;
                endcase
            end
            if (reg_wr)
            begin
                unique case (address[14:13])
                    cbm_pkg::GRP_BANK:
                    begin
                        if (!address[0])
                            bank_select_reg <= data;
                        else
                            bank_regs_reg[sel_r] <= bank_wval;
                    end
                    cbm_pkg::GRP_MIRROR:
                    begin
                        if (!address[0])
                        begin
                            mirror_h_reg <= data[0];
                        end
                        else
                        begin
                            ram_enable_reg   <= data[7];
                            ram_writable_reg <= data[7] && !data[6];
                        end
                    end
                    cbm_pkg::GRP_IRQ:
                    begin
                        if (!address[0])
                            irq_reload_reg <= data;
                        else
                            irq_counter_reg <= '0;
                    end
                    default:
                    begin
                        if (!address[0])
                        begin
                            irq_enable_reg <= 1'b0;
                            irq_line_reg   <= 1'b0;
                        end
                        else
                        begin
                            irq_enable_reg <= 1'b1;
                        end
                    end
                endcase
            end
            if (tick_run)
            begin
                if (irq_counter_reg == '0)
                begin
                    irq_counter_reg <= irq_reload_reg;
                end
                else
                begin
                    irq_counter_reg <= irq_counter_reg - 8'd1;
                    if (irq_counter_reg == 8'd1 && irq_enable_reg)
                        irq_line_reg <= 1'b1;
                end
            end
            if (cmd.accept)
                cnt_reg <= '1;
            else if (cmd.step)
                cnt_reg <= cnt_reg - cbm_pkg::STEP_W'(1);
        end
    end

    // Restoring remainder: one quotient bit a cycle, divisor shifts down
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tgt_reg <= tgt_acc;
            low_reg <= low_acc;
            we_reg  <= we_acc;
            wd_reg  <= wd_acc;
            rz_reg  <= rz_acc;
            rem_reg <= bank_acc;
            div_reg <= div_acc;
        end
        else if (cmd.step)
        begin
            if ({{cbm_pkg::BANK_W{1'b0}}, rem_reg} >= div_reg)
                rem_reg <= rem_reg - div_reg[cbm_pkg::BANK_W-1:0];
            div_reg <= div_reg >> 1;
        end
    end

    logic [18:0] maddr;

    always_comb
    begin
        case (tgt_reg)
            cbm_pkg::TGT_PRG_ROM: maddr = {rem_reg[5:0], low_reg};
            cbm_pkg::TGT_CHR:     maddr = {1'b0, rem_reg, low_reg[9:0]};
            default:              maddr = {6'b0, low_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_tgt_reg  <= tgt_reg;
            out_addr_reg <= maddr;
            out_we_reg   <= we_reg;
            out_wd_reg   <= wd_reg;
            out_rz_reg   <= rz_reg;
            out_irq_reg  <= irq_line_reg;
        end
    end

    assign m_tuser = out_tgt_reg;
    assign m_tdata = {2'b00, out_irq_reg, out_rz_reg, out_wd_reg, out_we_reg, out_addr_reg};

endmodule
